// ===== hdl/ccp_pkg.sv =====
// Shared constants and widths for the capsule push-out datapath.
package ccp_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int AxisFrac  = 14;
  localparam int PackW     = 3 * CoordBits;
  localparam int ScalW     = 16;

  localparam int RatioBits = 16;
  localparam int ParW      = RatioBits + 1;
  localparam logic [ParW-1:0] Pone = ParW'(1) << RatioBits;

  localparam int HprodW = 33;
  localparam int HalfW  = 18;
  localparam int PtW    = 19;
  localparam int RelW   = 20;
  localparam int MulW   = 40;
  localparam int SumW   = 42;
  localparam int DotW   = 32;
  localparam int WideW  = 64;
  localparam int MsW    = 37;
  localparam int CloseW = 21;
  localparam int DiffW  = 22;
  localparam int SqW    = 44;
  localparam int DistW  = SqW / 2;
  localparam int RsumW  = 17;
  localparam int NumW   = 40;
  localparam int MagW   = 41;
  localparam int PushQW = 18;
  localparam int OutSumW = 20;

endpackage

// ===== hdl/ccp_if.sv =====
// Handshake channels of the capsule push-out block.
interface ccp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ccp_pkg::PackW-1:0]     centre_a;
  logic [ccp_pkg::PackW-1:0]     axis_a;
  logic [ccp_pkg::ScalW-1:0]     height_a;
  logic [ccp_pkg::ScalW-1:0]     radius_a;
  logic [ccp_pkg::PackW-1:0]     centre_b;
  logic [ccp_pkg::PackW-1:0]     axis_b;
  logic [ccp_pkg::ScalW-1:0]     height_b;
  logic [ccp_pkg::ScalW-1:0]     radius_b;

  modport source (output valid, centre_a, axis_a, height_a, radius_a,
                  centre_b, axis_b, height_b, radius_b, input ready);
  modport sink (input valid, centre_a, axis_a, height_a, radius_a,
                centre_b, axis_b, height_b, radius_b, output ready);
endinterface

interface ccp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [ccp_pkg::PackW-1:0]     new_centre_b;

  modport source (output valid, hit, new_centre_b, input ready);
  modport sink (input valid, hit, new_centre_b, output ready);
endinterface

// ===== hdl/ccp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ccp_div #(
  parameter int DW = 22,
  parameter int QW = 18,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [QW-1:0] v_q;
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  logic [DW-1:0] rem_c  [QW];
  logic [QW-1:0] lo_c   [QW];
  logic [QW-1:0] quo_c  [QW];
  logic [DW-1:0] den_c  [QW];
  logic [SW-1:0] side_c [QW];
  logic [QW-1:0] v_c;

  logic [DW-1:0] rem_d  [QW];
  logic [QW-1:0] lo_d   [QW];
  logic [QW-1:0] quo_d  [QW];
  logic [DW:0]   trial  [QW];

  always_comb begin
    rem_c[0]  = num_hi_i;
    lo_c[0]   = num_lo_i;
    quo_c[0]  = '0;
    den_c[0]  = den_i;
    side_c[0] = side_i;
    v_c[0]    = valid_i;
    for (int k = 1; k < QW; k++) begin
      rem_c[k]  = rem_q[k-1];
      lo_c[k]   = lo_q[k-1];
      quo_c[k]  = quo_q[k-1];
      den_c[k]  = den_q[k-1];
      side_c[k] = side_q[k-1];
      v_c[k]    = v_q[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rem_c[k], lo_c[k][QW-1]};
      lo_d[k]  = lo_c[k] << 1;
      if (trial[k] >= {1'b0, den_c[k]}) begin
        rem_d[k] = DW'(trial[k] - {1'b0, den_c[k]});
        quo_d[k] = {quo_c[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][DW-1:0];
        quo_d[k] = {quo_c[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= rem_d[k];
        lo_q[k]   <= lo_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_c[k];
        side_q[k] <= side_c[k];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== hdl/ccp_ratio.sv =====
// Clamped ratio num/den in [0,1] with 16 fraction bits, pipelined.
module ccp_ratio #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [W-1:0]              num_i,
  input  logic [W-1:0]              den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [ccp_pkg::ParW-1:0]  ratio_o,
  output logic [SW-1:0]             side_o
);

  localparam int QW = ccp_pkg::RatioBits;

  logic          v1_q, v2_q;
  logic [W-1:0]  n1_q, d1_q;
  logic [SW-1:0] s1_q, s2_q;
  logic [W-2:0]  hi_q, den_q;
  logic          zero_q, one_q;

  logic          zero_d, one_d;
  logic          dv;
  logic [QW-1:0] quo;
  logic [SW+1:0] dside;

  assign zero_d = n1_q[W-1] || (n1_q == '0);
  assign one_d  = !zero_d && ($signed(n1_q) >= $signed(d1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q   <= den_i[W-1] ? W'(-num_i) : num_i;
      d1_q   <= den_i[W-1] ? W'(-den_i) : den_i;
      s1_q   <= side_i;
      zero_q <= zero_d;
      one_q  <= one_d;
      hi_q   <= (zero_d || one_d) ? '0 : n1_q[W-2:0];
      den_q  <= (zero_d || one_d) ? (W-1)'(1) : d1_q[W-2:0];
      s2_q   <= s1_q;
    end
  end

  ccp_div #(.DW(W - 1), .QW(QW), .SW(SW + 2)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (v2_q),
    .num_hi_i (hi_q),
    .num_lo_i ('0),
    .den_i    (den_q),
    .side_i   ({zero_q, one_q, s2_q}),
    .valid_o  (dv),
    .quo_o    (quo),
    .side_o   (dside)
  );

  assign valid_o = dv;
  assign side_o  = dside[SW-1:0];
  assign ratio_o = dside[SW+1] ? '0 :
                   dside[SW]   ? ccp_pkg::Pone : {1'b0, quo};

endmodule

// ===== hdl/ccp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ccp_sqrt #(
  parameter int VW = 44,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [VW-1:0]     val_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int N = VW / 2;

  logic [N-1:0]  v_q;
  logic [VW-1:0] val_q  [N];
  logic [VW-1:0] res_q  [N];
  logic [SW-1:0] side_q [N];

  logic [VW-1:0] val_c  [N];
  logic [VW-1:0] res_c  [N];
  logic [SW-1:0] side_c [N];
  logic [N-1:0]  v_c;
  logic [VW-1:0] val_d  [N];
  logic [VW-1:0] res_d  [N];
  logic [VW-1:0] bitv   [N];
  logic [VW-1:0] tsum   [N];

  always_comb begin
    val_c[0]  = val_i;
    res_c[0]  = '0;
    side_c[0] = side_i;
    v_c[0]    = valid_i;
    for (int k = 1; k < N; k++) begin
      val_c[k]  = val_q[k-1];
      res_c[k]  = res_q[k-1];
      side_c[k] = side_q[k-1];
      v_c[k]    = v_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      bitv[k] = VW'(1) << (VW - 2 - 2 * k);
      tsum[k] = res_c[k] + bitv[k];
      if (val_c[k] >= tsum[k]) begin
        val_d[k] = val_c[k] - tsum[k];
        res_d[k] = (res_c[k] >> 1) + bitv[k];
      end else begin
        val_d[k] = val_c[k];
        res_d[k] = res_c[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        val_q[k]  <= val_d[k];
        res_q[k]  <= res_d[k];
        side_q[k] <= side_c[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = res_q[N-1][N-1:0];
  assign side_o  = side_q[N-1];

endmodule

// ===== hdl/capsule_capsule_pushout_top.sv =====
// Capsule-capsule push-out: closest segment points, overlap test and push of B.
//
// Usage:
//   in_i carries one capsule pair per item (centres and axes packed x,y,z,
//   heights, radii). out_o returns one item per input item, in order: hit and
//   the new centre of capsule B (pushed out of A, or unchanged on a miss).
//   Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per cycle unless stalled; no dependence between items.
// Depth: set by the two 18-stage clamped ratio units (segment parameters), the
//   22-stage square root (distance) and the 18-stage push dividers, plus the
//   multiply stages.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty and ready.
// Stall: when out_o.ready is low while a result is held, the whole pipeline
//   freezes and in_i.ready drops in the same cycle; nothing is lost or
//   repeated. Bubbles inside the pipeline are not squeezed out during a stall.
module capsule_capsule_pushout_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  ccp_in_if.sink   in_i,
  ccp_out_if.source out_o
);

  localparam int CB    = ccp_pkg::CoordBits;
  localparam int PtW   = ccp_pkg::PtW;
  localparam int DotW  = ccp_pkg::DotW;
  localparam int WideW = ccp_pkg::WideW;
  localparam int ParW  = ccp_pkg::ParW;
  localparam int MulW  = ccp_pkg::MulW;
  localparam int SumW  = ccp_pkg::SumW;
  localparam int FB    = ccp_pkg::FracBits;

  typedef enum logic [1:0] {CaseBoth, CaseApt, CaseBpt, CaseGen} case_e;

  typedef struct packed {
    logic [2:0][PtW-1:0]            p1;
    logic [2:0][PtW-1:0]            p2;
    logic [2:0][PtW-1:0]            d1;
    logic [2:0][PtW-1:0]            d2;
    logic [2:0][CB-1:0]             cb;
    logic [ccp_pkg::RsumW-1:0]      rsum;
  } pt_t;

  typedef struct packed {
    logic [DotW-1:0] a;
    logic [DotW-1:0] b;
    logic [DotW-1:0] c;
    logic [DotW-1:0] e;
    logic [DotW-1:0] f;
    case_e           cse;
    pt_t             pt;
  } side1_t;

  typedef struct packed {
    logic [ParW-1:0] s_fix;
    logic [ParW-1:0] t_fix;
    logic            to_s;
    pt_t             pt;
  } side2_t;

  typedef struct packed {
    logic [2:0][ccp_pkg::DiffW-1:0] diff;
    logic [2:0][CB-1:0]             cb;
    logic [ccp_pkg::RsumW-1:0]      rsum;
  } side3_t;

  typedef struct packed {
    logic                           hit;
    logic                           dzero;
    logic [ccp_pkg::RsumW-1:0]      overlap;
    logic [2:0][CB-1:0]             cb;
  } fin_t;

  logic en;
  logic out_v_q;
  assign en          = !out_v_q || out_o.ready;
  assign in_i.ready  = en;

  // stage 1: half-axis products
  logic                           v1_q;
  logic [2:0][CB-1:0]             ca1_q, cb1_q;
  logic [2:0][ccp_pkg::HprodW-1:0] pha_q, phb_q;
  logic [ccp_pkg::ScalW-1:0]      ra1_q, rb1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ca1_q[i] <= in_i.centre_a[i*CB +: CB];
        cb1_q[i] <= in_i.centre_b[i*CB +: CB];
        pha_q[i] <= ccp_pkg::HprodW'($signed(in_i.axis_a[i*CB +: CB]) *
                                     $signed({1'b0, in_i.height_a}));
        phb_q[i] <= ccp_pkg::HprodW'($signed(in_i.axis_b[i*CB +: CB]) *
                                     $signed({1'b0, in_i.height_b}));
      end
      ra1_q <= in_i.radius_a;
      rb1_q <= in_i.radius_b;
    end
  end

  // stage 2: endpoints and segment vectors
  logic v2_q;
  pt_t  pt2_q;
  logic [2:0][ccp_pkg::RelW-1:0] r2_q;
  logic [2:0][ccp_pkg::HalfW-1:0] ha, hb;
  logic [2:0][PtW-1:0] p1c, p2c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ha[i]  = ccp_pkg::HalfW'(($signed({pha_q[i][ccp_pkg::HprodW-1], pha_q[i]}) +
                               35'sd16384) >>> (ccp_pkg::AxisFrac + 1));
      hb[i]  = ccp_pkg::HalfW'(($signed({phb_q[i][ccp_pkg::HprodW-1], phb_q[i]}) +
                               35'sd16384) >>> (ccp_pkg::AxisFrac + 1));
      p1c[i] = PtW'(PtW'($signed(ca1_q[i])) - PtW'($signed(ha[i])));
      p2c[i] = PtW'(PtW'($signed(cb1_q[i])) - PtW'($signed(hb[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt2_q.p1[i] <= p1c[i];
        pt2_q.p2[i] <= p2c[i];
        pt2_q.d1[i] <= {ha[i], 1'b0};
        pt2_q.d2[i] <= {hb[i], 1'b0};
        r2_q[i]     <= ccp_pkg::RelW'(ccp_pkg::RelW'($signed(p1c[i])) -
                                      ccp_pkg::RelW'($signed(p2c[i])));
      end
      pt2_q.cb   <= cb1_q;
      pt2_q.rsum <= ccp_pkg::RsumW'(ra1_q) + ccp_pkg::RsumW'(rb1_q);
    end
  end

  // stage 3: dot-product terms
  logic v3_q;
  pt_t  pt3_q;
  logic [2:0][MulW-1:0] ma_q, mb_q, mc_q, me_q, mf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma_q[i] <= MulW'($signed(pt2_q.d1[i])) * MulW'($signed(pt2_q.d1[i]));
        mb_q[i] <= MulW'($signed(pt2_q.d1[i])) * MulW'($signed(pt2_q.d2[i]));
        mc_q[i] <= MulW'($signed(pt2_q.d1[i])) * MulW'($signed(r2_q[i]));
        me_q[i] <= MulW'($signed(pt2_q.d2[i])) * MulW'($signed(pt2_q.d2[i]));
        mf_q[i] <= MulW'($signed(pt2_q.d2[i])) * MulW'($signed(r2_q[i]));
      end
      pt3_q <= pt2_q;
    end
  end

  // stage 4: rounded dot products
  function automatic logic [DotW-1:0] dot_rnd(input logic [2:0][MulW-1:0] m);
    logic signed [SumW-1:0] acc;
    acc = SumW'($signed(m[0])) + SumW'($signed(m[1])) + SumW'($signed(m[2])) +
          SumW'(1 << (FB - 1));
    return acc[FB +: DotW];
  endfunction

  logic v4_q;
  pt_t  pt4_q;
  logic [DotW-1:0] a4_q, b4_q, c4_q, e4_q, f4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q  <= dot_rnd(ma_q);
      b4_q  <= dot_rnd(mb_q);
      c4_q  <= dot_rnd(mc_q);
      e4_q  <= dot_rnd(me_q);
      f4_q  <= dot_rnd(mf_q);
      pt4_q <= pt3_q;
    end
  end

  // stage 5: determinant products
  logic v5_q;
  pt_t  pt5_q;
  logic [DotW-1:0]  a5_q, b5_q, c5_q, e5_q, f5_q;
  logic [WideW-1:0] ae5_q, bb5_q, bf5_q, ce5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ae5_q <= WideW'($signed(a4_q)) * WideW'($signed(e4_q));
      bb5_q <= WideW'($signed(b4_q)) * WideW'($signed(b4_q));
      bf5_q <= WideW'($signed(b4_q)) * WideW'($signed(f4_q));
      ce5_q <= WideW'($signed(c4_q)) * WideW'($signed(e4_q));
      a5_q  <= a4_q;
      b5_q  <= b4_q;
      c5_q  <= c4_q;
      e5_q  <= e4_q;
      f5_q  <= f4_q;
      pt5_q <= pt4_q;
    end
  end

  // stage 6: case selection, first ratio operands
  logic       v6_q;
  side1_t     sd6_q;
  logic [WideW-1:0] n6_q, d6_q;
  logic [WideW-1:0] denom, snum;
  logic       apos, epos;
  case_e      cse;

  assign denom = ae5_q - bb5_q;
  assign snum  = bf5_q - ce5_q;
  assign apos  = !a5_q[DotW-1] && (a5_q != '0);
  assign epos  = !e5_q[DotW-1] && (e5_q != '0);

  always_comb begin
    if (!apos && !epos) begin
      cse = CaseBoth;
    end else if (!apos) begin
      cse = CaseApt;
    end else if (!epos) begin
      cse = CaseBpt;
    end else if (denom == '0) begin
      cse = CaseApt;
    end else begin
      cse = CaseGen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd6_q.a   <= a5_q;
      sd6_q.b   <= b5_q;
      sd6_q.c   <= c5_q;
      sd6_q.e   <= e5_q;
      sd6_q.f   <= f5_q;
      sd6_q.cse <= cse;
      sd6_q.pt  <= pt5_q;
      n6_q      <= (cse == CaseGen) ? snum : '0;
      d6_q      <= (cse == CaseGen) ? denom : WideW'(1);
    end
  end

  logic                r1v;
  logic [ParW-1:0]     s1;
  logic [$bits(side1_t)-1:0] r1side;
  side1_t              sd7;

  ccp_ratio #(.W(WideW), .SW($bits(side1_t))) u_ratio_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (n6_q),
    .den_i   (d6_q),
    .side_i  (sd6_q),
    .valid_o (r1v),
    .ratio_o (s1),
    .side_o  (r1side)
  );
  assign sd7 = side1_t'(r1side);

  // stage 7: b*s
  logic       v7_q;
  side1_t     sd7_q;
  logic [ParW-1:0]  s7_q;
  logic [WideW-1:0] bs7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs7_q <= WideW'($signed(sd7.b)) * WideW'($signed({1'b0, s1}));
      s7_q  <= s1;
      sd7_q <= sd7;
    end
  end

  // stage 8: t numerator, second ratio operands
  logic       v8_q;
  side2_t     sd8_q;
  logic [WideW-1:0] n8_q, d8_q;
  logic [WideW-1:0] tnum, et, ext_a, ext_c, ext_f, ext_e;
  logic [WideW-1:0] n8, d8;
  side2_t     sd8;

  function automatic logic [WideW-1:0] ext_b_minus_c(input logic [DotW-1:0] b,
                                                     input logic [DotW-1:0] c);
    return WideW'($signed(b)) - WideW'($signed(c));
  endfunction

  assign ext_a = WideW'($signed(sd7_q.a));
  assign ext_c = WideW'($signed(sd7_q.c));
  assign ext_f = WideW'($signed(sd7_q.f));
  assign ext_e = WideW'($signed(sd7_q.e));
  assign et    = ext_e << ccp_pkg::RatioBits;
  assign tnum  = bs7_q + (ext_f << ccp_pkg::RatioBits);

  always_comb begin
    sd8.pt    = sd7_q.pt;
    sd8.s_fix = '0;
    sd8.t_fix = '0;
    sd8.to_s  = 1'b1;
    n8        = '0;
    d8        = WideW'(1);
    case (sd7_q.cse)
      CaseBoth: begin
        sd8.to_s = 1'b1;
      end
      CaseApt: begin
        sd8.to_s = 1'b0;
        n8       = ext_f;
        d8       = ext_e;
      end
      CaseBpt: begin
        n8 = WideW'(-ext_c);
        d8 = ext_a;
      end
      CaseGen: begin
        if (tnum[WideW-1]) begin
          n8 = WideW'(-ext_c);
          d8 = ext_a;
        end else if ($signed(tnum) > $signed(et)) begin
          sd8.t_fix = ccp_pkg::Pone;
          n8        = ext_b_minus_c(sd7_q.b, sd7_q.c);
          d8        = ext_a;
        end else begin
          sd8.to_s  = 1'b0;
          sd8.s_fix = s7_q;
          n8        = tnum;
          d8        = et;
        end
      end
      default: begin
        sd8.to_s = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd8_q <= sd8;
      n8_q  <= n8;
      d8_q  <= d8;
    end
  end

  logic                r2v;
  logic [ParW-1:0]     q2;
  logic [$bits(side2_t)-1:0] r2side;
  side2_t              sd9;

  ccp_ratio #(.W(WideW), .SW($bits(side2_t))) u_ratio_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_i   (n8_q),
    .den_i   (d8_q),
    .side_i  (sd8_q),
    .valid_o (r2v),
    .ratio_o (q2),
    .side_o  (r2side)
  );
  assign sd9 = side2_t'(r2side);

  // stage 9: closest-point offsets
  logic       v9_q;
  pt_t        pt9_q;
  logic [2:0][ccp_pkg::MsW-1:0] ms9_q, mt9_q;
  logic [ParW-1:0] s9, t9;

  assign s9 = sd9.to_s ? q2 : sd9.s_fix;
  assign t9 = sd9.to_s ? sd9.t_fix : q2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ms9_q[i] <= ccp_pkg::MsW'($signed(sd9.pt.d1[i])) *
                    ccp_pkg::MsW'($signed({1'b0, s9}));
        mt9_q[i] <= ccp_pkg::MsW'($signed(sd9.pt.d2[i])) *
                    ccp_pkg::MsW'($signed({1'b0, t9}));
      end
      pt9_q <= sd9.pt;
    end
  end

  // stage 10: closest points and separation
  logic       v10_q;
  logic [2:0][ccp_pkg::DiffW-1:0] df10_q;
  logic [2:0][CB-1:0]             cb10_q;
  logic [ccp_pkg::RsumW-1:0]      rs10_q;
  logic [2:0][ccp_pkg::CloseW-1:0] c1, c2;
  logic [ccp_pkg::MsW-1:0] rs_s [3];
  logic [ccp_pkg::MsW-1:0] rs_t [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs_s[i] = ms9_q[i] + ccp_pkg::MsW'(1 << (ccp_pkg::RatioBits - 1));
      rs_t[i] = mt9_q[i] + ccp_pkg::MsW'(1 << (ccp_pkg::RatioBits - 1));
      c1[i] = ccp_pkg::CloseW'($signed(pt9_q.p1[i])) +
              ccp_pkg::CloseW'($signed(rs_s[i][ccp_pkg::MsW-1:ccp_pkg::RatioBits]));
      c2[i] = ccp_pkg::CloseW'($signed(pt9_q.p2[i])) +
              ccp_pkg::CloseW'($signed(rs_t[i][ccp_pkg::MsW-1:ccp_pkg::RatioBits]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        df10_q[i] <= ccp_pkg::DiffW'($signed(c2[i])) - ccp_pkg::DiffW'($signed(c1[i]));
      end
      cb10_q <= pt9_q.cb;
      rs10_q <= pt9_q.rsum;
    end
  end

  // stage 11: squares
  logic       v11_q;
  side3_t     sd11_q;
  logic [2:0][ccp_pkg::SqW-1:0] sq11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq11_q[i] <= ccp_pkg::SqW'($signed(df10_q[i])) * ccp_pkg::SqW'($signed(df10_q[i]));
      end
      sd11_q.diff <= df10_q;
      sd11_q.cb   <= cb10_q;
      sd11_q.rsum <= rs10_q;
    end
  end

  // stage 12: squared distance
  logic       v12_q;
  side3_t     sd12_q;
  logic [ccp_pkg::SqW-1:0] sq12_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq12_q <= sq11_q[0] + sq11_q[1] + sq11_q[2];
      sd12_q <= sd11_q;
    end
  end

  logic                       qv;
  logic [ccp_pkg::DistW-1:0]  sep_len;
  logic [$bits(side3_t)-1:0]  qside;
  side3_t                     sd13;

  ccp_sqrt #(.VW(ccp_pkg::SqW), .SW($bits(side3_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v12_q),
    .val_i   (sq12_q),
    .side_i  (sd12_q),
    .valid_o (qv),
    .root_o  (sep_len),
    .side_o  (qside)
  );
  assign sd13 = side3_t'(qside);

  // stage 13: overlap test and push numerators
  logic       v13_q;
  fin_t       fn13_q;
  logic [ccp_pkg::DistW-1:0] dist13_q;
  logic [2:0][ccp_pkg::NumW-1:0] num13_q;
  logic [ccp_pkg::RsumW-1:0] ovl;

  assign ovl = sd13.rsum - sep_len[ccp_pkg::RsumW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num13_q[i] <= ccp_pkg::NumW'($signed(sd13.diff[i])) *
                      ccp_pkg::NumW'($signed({1'b0, ovl}));
      end
      fn13_q.hit     <= ccp_pkg::DistW'(sd13.rsum) > sep_len;
      fn13_q.dzero   <= sep_len == '0;
      fn13_q.overlap <= ovl;
      fn13_q.cb      <= sd13.cb;
      dist13_q       <= sep_len;
    end
  end

  // stage 14: rounded magnitudes for the push divider
  logic       v14_q;
  fin_t       fn14_q;
  logic [2:0] neg14_q;
  logic [2:0][ccp_pkg::DistW-1:0]  hi14_q;
  logic [2:0][ccp_pkg::PushQW-1:0] lo14_q;
  logic [ccp_pkg::DistW-1:0] den14_q;
  logic [2:0][ccp_pkg::MagW-1:0]   mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = ccp_pkg::MagW'(num13_q[i][ccp_pkg::NumW-1] ?
                              ccp_pkg::NumW'(-num13_q[i]) : num13_q[i]) +
               ccp_pkg::MagW'(dist13_q >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg14_q[i] <= num13_q[i][ccp_pkg::NumW-1];
        hi14_q[i]  <= mag[i][ccp_pkg::PushQW +: ccp_pkg::DistW];
        lo14_q[i]  <= mag[i][ccp_pkg::PushQW-1:0];
      end
      den14_q <= (dist13_q == '0) ? ccp_pkg::DistW'(1) : dist13_q;
      fn14_q  <= fn13_q;
    end
  end

  logic [2:0] pv;
  logic [2:0][ccp_pkg::PushQW-1:0] pq;
  logic [$bits(fin_t):0] p0side;
  logic p1neg, p2neg;
  fin_t fn15;

  ccp_div #(.DW(ccp_pkg::DistW), .QW(ccp_pkg::PushQW), .SW($bits(fin_t) + 1)) u_push_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v14_q),
    .num_hi_i (hi14_q[0]),
    .num_lo_i (lo14_q[0]),
    .den_i    (den14_q),
    .side_i   ({neg14_q[0], fn14_q}),
    .valid_o  (pv[0]),
    .quo_o    (pq[0]),
    .side_o   (p0side)
  );

  ccp_div #(.DW(ccp_pkg::DistW), .QW(ccp_pkg::PushQW), .SW(1)) u_push_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v14_q),
    .num_hi_i (hi14_q[1]),
    .num_lo_i (lo14_q[1]),
    .den_i    (den14_q),
    .side_i   (neg14_q[1]),
    .valid_o  (pv[1]),
    .quo_o    (pq[1]),
    .side_o   (p1neg)
  );

  ccp_div #(.DW(ccp_pkg::DistW), .QW(ccp_pkg::PushQW), .SW(1)) u_push_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v14_q),
    .num_hi_i (hi14_q[2]),
    .num_lo_i (lo14_q[2]),
    .den_i    (den14_q),
    .side_i   (neg14_q[2]),
    .valid_o  (pv[2]),
    .quo_o    (pq[2]),
    .side_o   (p2neg)
  );

  assign fn15 = fin_t'(p0side[$bits(fin_t)-1:0]);

  // stage 15: push, saturate, output register
  logic [2:0] negf;
  logic [2:0][ccp_pkg::OutSumW-1:0] push, tot;
  logic [ccp_pkg::PackW-1:0] packed_c;
  logic hit_q;
  logic [ccp_pkg::PackW-1:0] centre_q;

  assign negf = {p2neg, p1neg, p0side[$bits(fin_t)]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fn15.dzero) begin
        push[i] = (i == 1) ? ccp_pkg::OutSumW'(fn15.overlap) : '0;
      end else if (negf[i]) begin
        push[i] = ccp_pkg::OutSumW'(-ccp_pkg::OutSumW'(pq[i]));
      end else begin
        push[i] = ccp_pkg::OutSumW'(pq[i]);
      end
      tot[i] = ccp_pkg::OutSumW'($signed(fn15.cb[i])) + push[i];
      if (!tot[i][ccp_pkg::OutSumW-1] && (tot[i][ccp_pkg::OutSumW-2:CB-1] != '0)) begin
        packed_c[i*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
      end else if (tot[i][ccp_pkg::OutSumW-1] &&
                   (tot[i][ccp_pkg::OutSumW-2:CB-1] != '1)) begin
        packed_c[i*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        packed_c[i*CB +: CB] = tot[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q    <= fn15.hit;
      centre_q <= fn15.hit ? packed_c : fn15.cb;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      v9_q    <= 1'b0;
      v10_q   <= 1'b0;
      v11_q   <= 1'b0;
      v12_q   <= 1'b0;
      v13_q   <= 1'b0;
      v14_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= r1v;
      v8_q    <= v7_q;
      v9_q    <= r2v;
      v10_q   <= v9_q;
      v11_q   <= v10_q;
      v12_q   <= v11_q;
      v13_q   <= qv;
      v14_q   <= v13_q;
      out_v_q <= pv[0] && pv[1] && pv[2];
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.hit          = hit_q;
  assign out_o.new_centre_b = centre_q;

endmodule

// ===== tb/capsule_capsule_pushout_top_tb.sv =====
// Testbench for the capsule push-out block: directed and random capsule pairs checked by a predictor.
`timescale 1ns / 100ps

module capsule_capsule_pushout_top_tb;

  typedef struct packed {
    logic [ccp_pkg::PackW-1:0] ca;
    logic [ccp_pkg::PackW-1:0] xa;
    logic [ccp_pkg::ScalW-1:0] ha;
    logic [ccp_pkg::ScalW-1:0] ra;
    logic [ccp_pkg::PackW-1:0] cb;
    logic [ccp_pkg::PackW-1:0] xb;
    logic [ccp_pkg::ScalW-1:0] hb;
    logic [ccp_pkg::ScalW-1:0] rb;
  } pair_t;

  typedef struct packed {
    logic                      hit;
    logic [ccp_pkg::PackW-1:0] centre;
  } push_t;

  localparam longint OneP = 65536;
  localparam int CycleLimit = 600000;
  localparam int CBits = ccp_pkg::CoordBits;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ccp_in_if in_ch ();
  ccp_out_if out_ch ();

  capsule_capsule_pushout_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  push_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit pushy_stall = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint field_of(logic [ccp_pkg::PackW-1:0] v, int i);
    logic signed [CBits-1:0] x;
    x = v[i*CBits +: CBits];
    return longint'(x);
  endfunction

  function automatic longint round_sh(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_div(longint num, longint den);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    if (num >= den) return OneP;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint dot(longint u[3], longint v[3]);
    return round_sh(u[0]*v[0] + u[1]*v[1] + u[2]*v[2], ccp_pkg::FracBits);
  endfunction

  function automatic push_t predict_push(pair_t p);
    longint ca[3], cb[3], p1[3], p2[3], d1[3], d2[3], r[3], diff[3];
    longint a, b, c, e, f, s, t, rsum, overlap, hx, hy, den, tnum, sep, num, push, v;
    longint unsigned sq;
    push_t res;
    s = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      hx = round_sh(field_of(p.xa, i) * longint'(p.ha), ccp_pkg::AxisFrac + 1);
      hy = round_sh(field_of(p.xb, i) * longint'(p.hb), ccp_pkg::AxisFrac + 1);
      ca[i] = field_of(p.ca, i);
      cb[i] = field_of(p.cb, i);
      p1[i] = ca[i] - hx;
      p2[i] = cb[i] - hy;
      d1[i] = 2 * hx;
      d2[i] = 2 * hy;
      r[i] = p1[i] - p2[i];
    end
    a = dot(d1, d1);
    e = dot(d2, d2);
    f = dot(d2, r);
    c = dot(d1, r);
    b = dot(d1, d2);
    if (a <= 0 && e <= 0) begin
      s = 0;
      t = 0;
    end else if (a <= 0) begin
      t = clamp_div(f, e);
    end else if (e <= 0) begin
      s = clamp_div(-c, a);
    end else begin
      den = a * e - b * b;
      if (den != 0) begin
        s = clamp_div(b * f - c * e, den);
        tnum = b * s + f * OneP;
        if (tnum < 0) begin
          t = 0;
          s = clamp_div(-c, a);
        end else if (tnum > e * OneP) begin
          t = OneP;
          s = clamp_div(b - c, a);
        end else begin
          t = tnum / e;
        end
      end else begin
        t = clamp_div(f, e);
      end
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = (p2[i] + round_sh(d2[i] * t, 16)) - (p1[i] + round_sh(d1[i] * s, 16));
      sq += longint'(diff[i] * diff[i]);
    end
    sep = floor_sqrt(sq);
    rsum = longint'(p.ra) + longint'(p.rb);
    res.hit = sep < rsum;
    res.centre = p.cb;
    if (res.hit) begin
      overlap = rsum - sep;
      for (int i = 0; i < 3; i++) begin
        if (sep > 0) begin
          num = diff[i] * overlap;
          if (num >= 0) push = (num + sep / 2) / sep;
          else push = -((-num + sep / 2) / sep);
        end else begin
          push = (i == 1) ? overlap : 0;
        end
        v = cb[i] + push;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        res.centre[i*CBits +: CBits] = v[CBits-1:0];
      end
    end
    return res;
  endfunction

  task automatic report(string what, push_t got, push_t want);
    errors++;
    $display("MISMATCH %s: got hit=%0b c=%h, want hit=%0b c=%h",
             what, got.hit, got.centre, want.hit, want.centre);
  endtask

  task automatic send_pair(pair_t p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.centre_a, in_ch.axis_a, in_ch.height_a, in_ch.radius_a,
     in_ch.centre_b, in_ch.axis_b, in_ch.height_b, in_ch.radius_b} <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_q.push_back(predict_push(p));
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ccp_pkg::PackW-1:0] vec3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic pair_t rand_pair(bit full);
    pair_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (!full) begin
      // keep capsules close so overlaps are common
      p.ca = vec3($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                  $urandom_range(0, 2047) - 1024);
      p.cb = vec3(int'(field_of(p.ca, 0) + $urandom_range(0, 1023) - 512),
                  int'(field_of(p.ca, 1) + $urandom_range(0, 1023) - 512),
                  int'(field_of(p.ca, 2) + $urandom_range(0, 1023) - 512));
      p.xa = vec3($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                  $urandom_range(0, 32767) - 16384);
      p.xb = ($urandom_range(0, 7) == 0) ? p.xa :
             vec3($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                  $urandom_range(0, 32767) - 16384);
      p.ha = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 1279));
      p.hb = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 1279));
      p.ra = 16'($urandom_range(0, 511));
      p.rb = 16'($urandom_range(0, 511));
    end
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '0;
    send_pair(p);  // both points, coincident
    p.ra = 16'h0100;
    send_pair(p);
    p.cb = vec3(100, 0, 0);
    send_pair(p);
    p.xa = vec3(16384, 0, 0);
    p.ha = 16'h0200;
    send_pair(p);  // B a point
    p.xa = '0;
    p.xb = vec3(0, 16384, 0);
    p.hb = 16'h0200;
    send_pair(p);  // A a point
    p.xa = vec3(0, 16384, 0);
    p.ha = 16'h0300;
    send_pair(p);  // parallel
    p.xa = vec3(0, 0, 16384);
    send_pair(p);  // skew
    p.cb = vec3(32767, 32767, 32767);
    p.ra = 16'hFFFF;
    p.rb = 16'hFFFF;
    send_pair(p);  // saturate high
    p.ca = vec3(32767, 32767, 32767);
    p.cb = vec3(-32768, -32768, -32768);
    send_pair(p);  // saturate low
    p = '1;
    send_pair(p);
    p = '0;
    p.xa = vec3(-32768, 32767, -32768);
    p.xb = vec3(32767, -32768, 32767);
    p.ha = 16'hFFFF;
    p.hb = 16'hFFFF;
    p.ra = 16'h0010;
    send_pair(p);
    p.cb = vec3(20000, -20000, 5);
    p.ra = '0;
    send_pair(p);  // miss
  endtask

  task automatic test_random(int n, bit full);
    for (int i = 0; i < n; i++) send_pair(rand_pair(full));
  endtask

  task automatic test_drain_pause();
    go_idle();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_back_to_back(int n);
    calm = 1'b1;
    pushy_stall = 1'b0;
    test_random(n, 1'b0);
    go_idle();
  endtask

  // output side: random stalls and checking
  initial begin
    push_t got, want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.hit = out_ch.hit;
        got.centre = out_ch.new_centre_b;
        if (pending_q.size() == 0) begin
          report("unexpected result", got, got);
        end else begin
          want = pending_q.pop_front();
          if (got.hit !== want.hit) report("hit", got, want);
          if (got.centre !== want.centre) report("new_centre_b", got, want);
        end
      end
      if (pushy_stall && rst_ni && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= rst_ni;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("capsule_capsule_pushout_top_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    {in_ch.centre_a, in_ch.axis_a, in_ch.height_a, in_ch.radius_a,
     in_ch.centre_b, in_ch.axis_b, in_ch.height_b, in_ch.radius_b} <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(1200, 1'b0);
    test_random(300, 1'b1);
    test_drain_pause();
    test_back_to_back(400);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("capsule_capsule_pushout_top_tb: done, clean");
    end else begin
      $display("capsule_capsule_pushout_top_tb: done, errors");
    end
    $finish;
  end

endmodule
